/* sv/eiptf_pkg.sv */
// ----------------------------------------------------------------------------
// eiptf_pkg
// Shared types and constants for the Ethernet/IPv4/TCP header filter.
// ----------------------------------------------------------------------------
package eiptf_pkg;

	localparam logic [15:0] ETH_HDR_LEN    = 16'd14;
	localparam logic [6:0]  IP_MIN_LEN     = 7'd20;
	localparam logic [6:0]  TCP_MIN_LEN    = 7'd20;
	localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
	localparam logic [7:0]  PROTO_TCP      = 8'd6;
	localparam logic [15:0] PORT_RESET     = 16'd80;
	localparam logic [15:0] POS_MAX        = 16'hFFFF;

	// byte positions of the fixed-place header fields
	localparam logic [15:0] POS_ETYPE_HI = 16'd12;
	localparam logic [15:0] POS_ETYPE_LO = 16'd13;
	localparam logic [15:0] POS_IHL      = 16'd14;
	localparam logic [15:0] POS_LEN_HI   = 16'd16;
	localparam logic [15:0] POS_LEN_LO   = 16'd17;
	localparam logic [15:0] POS_PROTO    = 16'd23;

	// verdict codes
	localparam logic [3:0] ST_ACCEPT    = 4'd0;
	localparam logic [3:0] ST_SHORT_ETH = 4'd1;
	localparam logic [3:0] ST_NOT_IPV4  = 4'd2;
	localparam logic [3:0] ST_SHORT_IP  = 4'd3;
	localparam logic [3:0] ST_BAD_IHL   = 4'd4;
	localparam logic [3:0] ST_NOT_TCP   = 4'd5;
	localparam logic [3:0] ST_SHORT_TCP = 4'd6;
	localparam logic [3:0] ST_BAD_DOFF  = 4'd7;
	localparam logic [3:0] ST_PORT_PAYL = 4'd8;

	// header fields gathered over one frame
	typedef struct packed {
		logic [15:0] frame_len;
		logic [15:0] ether_type;
		logic [3:0]  ihl;
		logic [15:0] ip_len;
		logic [7:0]  proto;
		logic [15:0] src_port;
		logic [3:0]  doff;
	} hdr_fields_t;

	typedef struct packed {
		logic [3:0]  status;
		logic [5:0]  ip_header_bytes;
		logic [5:0]  tcp_header_bytes;
		logic [7:0]  payload_offset;
		logic [15:0] ip_total_length;
		logic [15:0] frame_bytes;
	} verdict_t;

endpackage

/* sv/eiptf_if.sv */
// ----------------------------------------------------------------------------
// eiptf_if
// Valid/ready channels for frame bytes in and verdict words out.
// ----------------------------------------------------------------------------
interface eiptf_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source(output valid, output data_byte, output last_byte, input ready);
	modport sink(input valid, input data_byte, input last_byte, output ready);
endinterface

interface eiptf_verdict_if;
	logic        valid;
	logic        ready;
	logic [3:0]  status;
	logic [5:0]  ip_header_bytes;
	logic [5:0]  tcp_header_bytes;
	logic [7:0]  payload_offset;
	logic [15:0] ip_total_length;
	logic [15:0] frame_bytes;

	modport source(output valid, output status, output ip_header_bytes,
		output tcp_header_bytes, output payload_offset, output ip_total_length,
		output frame_bytes, input ready);
	modport sink(input valid, input status, input ip_header_bytes,
		input tcp_header_bytes, input payload_offset, input ip_total_length,
		input frame_bytes, output ready);
endinterface

/* sv/eiptf_verdict.sv */
// ----------------------------------------------------------------------------
// eiptf_verdict
// Runs the header checks in order and forms the verdict word.
// ----------------------------------------------------------------------------
module eiptf_verdict (
	input  eiptf_pkg::hdr_fields_t hdr,
	input  logic [15:0]            monitored_port,
	output eiptf_pkg::verdict_t    verdict
);
	import eiptf_pkg::*;

	logic [5:0] iph;
	logic [5:0] tcph;
	logic [6:0] tcp_start;
	logic [6:0] hdr_sum;
	logic [3:0] status;

	assign iph       = {hdr.ihl, 2'b00};
	assign tcph      = {hdr.doff, 2'b00};
	assign tcp_start = 7'(ETH_HDR_LEN) + {1'b0, iph};
	assign hdr_sum   = {1'b0, iph} + {1'b0, tcph} + 7'd1;

	always_comb begin
		if (hdr.frame_len < ETH_HDR_LEN) begin
			status = ST_SHORT_ETH;
		end else if (hdr.ether_type != ETHERTYPE_IPV4) begin
			status = ST_NOT_IPV4;
		end else if (hdr.frame_len < ETH_HDR_LEN + 16'(IP_MIN_LEN)) begin
			status = ST_SHORT_IP;
		end else if ({1'b0, iph} < IP_MIN_LEN) begin
			status = ST_BAD_IHL;
		end else if (hdr.proto != PROTO_TCP) begin
			status = ST_NOT_TCP;
		end else if (hdr.frame_len < 16'(tcp_start) + 16'(TCP_MIN_LEN)) begin
			status = ST_SHORT_TCP;
		end else if ({1'b0, tcph} < TCP_MIN_LEN) begin
			status = ST_BAD_DOFF;
		end else if (hdr.src_port != monitored_port || hdr.ip_len < 16'(hdr_sum)) begin
			status = ST_PORT_PAYL;
		end else begin
			status = ST_ACCEPT;
		end
	end

	always_comb begin
		verdict.status          = status;
		verdict.frame_bytes     = hdr.frame_len;
		verdict.ip_header_bytes = (status == ST_ACCEPT || status >= ST_BAD_IHL) ? iph : '0;
		verdict.ip_total_length = (status == ST_ACCEPT || status >= ST_BAD_IHL) ? hdr.ip_len
			: '0;
		verdict.tcp_header_bytes = (status == ST_ACCEPT || status >= ST_BAD_DOFF) ? tcph : '0;
		verdict.payload_offset   = (status == ST_ACCEPT) ? ({1'b0, tcp_start} + {2'b00, tcph})
			: '0;
	end

endmodule

/* sv/eth_ipv4_tcp_header_filter_core.sv */
// ----------------------------------------------------------------------------
// eth_ipv4_tcp_header_filter_core
// Byte-stream Ethernet/IPv4/TCP header filter with a verdict per frame.
// ----------------------------------------------------------------------------
// Throughput: one frame byte per cycle, sustained, while verdicts are drained.
// The verdict word is formed as its last byte passes the input register,
//   then held in the verdict register until it is taken.
// A pending verdict stalls only the next last byte; ordinary bytes keep flowing.
// Reset (arst_n low, asynchronous): all frame state cleared, no verdict pending,
//   monitored port back to 80.
module eth_ipv4_tcp_header_filter_core (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic [15:0]            cfg_wr_data,
	eiptf_byte_if.sink             frame,
	eiptf_verdict_if.source        result
);
	import eiptf_pkg::*;

	// configuration
	logic [15:0] mon_port_q;

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// per-frame capture state
	logic [15:0] pos_q;
	logic [15:0] etype_q;
	logic [3:0]  ihl_q;
	logic [15:0] iplen_q;
	logic [7:0]  proto_q;
	logic [15:0] sport_q;
	logic [3:0]  doff_q;

	// verdict register
	logic     res_valid_q;
	verdict_t res_q;

	logic        advance;
	logic [6:0]  tcp_start;
	logic        tcp_en;
	hdr_fields_t hdr_n;
	verdict_t    verdict;

	// The word in s1 moves on unless it is a last byte and the verdict
	// register is still occupied.
	assign advance     = valid_s1 && (!last_s1 || !res_valid_q || result.ready);
	assign frame.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mon_port_q <= PORT_RESET;
		end else if (cfg_wr_en) begin
			mon_port_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (frame.ready) begin
			valid_s1 <= frame.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (frame.ready && frame.valid) begin
			byte_s1 <= frame.data_byte;
			last_s1 <= frame.last_byte;
		end
	end

	// TCP start uses the IHL held before this byte, while the capture enable
	// uses the IHL after it: at position 14 of a fresh frame the two differ,
	// and the source port briefly picks up the IHL byte. Later writes at the
	// real TCP start overwrite it whenever the port is actually checked.
	assign tcp_start = 7'(ETH_HDR_LEN) + {1'b0, ihl_q, 2'b00};

	always_comb begin
		hdr_n.frame_len  = (pos_q != POS_MAX) ? pos_q + 16'd1 : pos_q;
		hdr_n.ether_type = etype_q;
		hdr_n.ihl        = ihl_q;
		hdr_n.ip_len     = iplen_q;
		hdr_n.proto      = proto_q;
		hdr_n.src_port   = sport_q;
		hdr_n.doff       = doff_q;
		if (pos_q == POS_ETYPE_HI) hdr_n.ether_type[15:8] = byte_s1;
		if (pos_q == POS_ETYPE_LO) hdr_n.ether_type[7:0]  = byte_s1;
		if (pos_q == POS_IHL)      hdr_n.ihl              = byte_s1[3:0];
		if (pos_q == POS_LEN_HI)   hdr_n.ip_len[15:8]     = byte_s1;
		if (pos_q == POS_LEN_LO)   hdr_n.ip_len[7:0]      = byte_s1;
		if (pos_q == POS_PROTO)    hdr_n.proto            = byte_s1;
		if (tcp_en) begin
			if (pos_q == 16'(tcp_start))          hdr_n.src_port[15:8] = byte_s1;
			if (pos_q == 16'(tcp_start + 7'd1))   hdr_n.src_port[7:0]  = byte_s1;
			if (pos_q == 16'(tcp_start + 7'd12))  hdr_n.doff           = byte_s1[7:4];
		end
	end

	assign tcp_en = (pos_q == POS_IHL) ? (byte_s1[3:0] >= 4'd5) : (ihl_q >= 4'd5);

	eiptf_verdict u_verdict (
		.hdr            (hdr_n),
		.monitored_port (mon_port_q),
		.verdict        (verdict)
	);

	// capture state: cleared after every last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			etype_q <= '0;
			ihl_q   <= '0;
			iplen_q <= '0;
			proto_q <= '0;
			sport_q <= '0;
			doff_q  <= '0;
		end else if (advance) begin
			if (last_s1) begin
				pos_q   <= '0;
				etype_q <= '0;
				ihl_q   <= '0;
				iplen_q <= '0;
				proto_q <= '0;
				sport_q <= '0;
				doff_q  <= '0;
			end else begin
				pos_q   <= hdr_n.frame_len;
				etype_q <= hdr_n.ether_type;
				ihl_q   <= hdr_n.ihl;
				iplen_q <= hdr_n.ip_len;
				proto_q <= hdr_n.proto;
				sport_q <= hdr_n.src_port;
				doff_q  <= hdr_n.doff;
			end
		end
	end

	// verdict register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			res_q <= verdict;
		end
	end

	assign result.valid            = res_valid_q;
	assign result.status           = res_q.status;
	assign result.ip_header_bytes  = res_q.ip_header_bytes;
	assign result.tcp_header_bytes = res_q.tcp_header_bytes;
	assign result.payload_offset   = res_q.payload_offset;
	assign result.ip_total_length  = res_q.ip_total_length;
	assign result.frame_bytes      = res_q.frame_bytes;

	// --- checks ---------------------------------------------------------------

	// an accepted frame's payload offset is the sum of the three headers
	a_offset_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.status == ST_ACCEPT) |->
		(res_q.payload_offset == 8'd14 + {2'b00, res_q.ip_header_bytes}
			+ {2'b00, res_q.tcp_header_bytes}))
		else $error("payload offset disagrees with header lengths");

	// an accepted frame carries full-size IP and TCP headers
	a_accept_hdrs: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.status == ST_ACCEPT) |->
		(res_q.ip_header_bytes >= 6'd20 && res_q.tcp_header_bytes >= 6'd20))
		else $error("accepted frame with short header length");

	// the last byte of a frame restarts the byte count
	a_pos_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && last_s1) |=> (pos_q == 16'd0))
		else $error("byte position not cleared after last byte");

	// a held last byte must stall the input while the verdict is blocked
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && last_s1 && res_valid_q && !result.ready) |-> !frame.ready)
		else $error("input taken while verdict register blocked");

endmodule

/* bench/eth_ipv4_tcp_header_filter_core_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// eth_ipv4_tcp_header_filter_core_test
// Self-checking bench: frames go in a byte at a time and each verdict word is
// compared with an in-bench model of the header checks.
// ----------------------------------------------------------------------------
module eth_ipv4_tcp_header_filter_core_test;
	import eiptf_pkg::*;

	// Longest run of cycles with no word moving on either channel.
	localparam int STALL_LIMIT = 2000;
	// Cycles to let the verdict pipeline drain before touching the register.
	localparam int DRAIN_CYCLES = 4;
	// Bytes of random traffic per phase, roughly.
	localparam int PHASE_BYTES = 40;

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [15:0] cfg_wr_data;

	eiptf_byte_if    frame_ch();
	eiptf_verdict_if verdict_ch();

	eth_ipv4_tcp_header_filter_core uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.frame       (frame_ch),
		.result      (verdict_ch)
	);

	// Model state: header fields gathered so far and the monitored port.
	hdr_fields_t hdr_seen;
	logic [15:0] port_setting;
	verdict_t    expected_verdicts[$];

	int  error_count;
	int  bytes_sent;
	int  quiet_cycles;
	// Random gaps on both channels; cleared for stretches at full rate.
	bit  gaps_enabled;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Header model. Fields are picked up at fixed positions; the TCP start
	// is worked out from the IHL held before this byte, as the block does.
	// Returns 1 with the verdict when the byte closes the frame.
	// ------------------------------------------------------------------
	function automatic bit track_frame_byte(input logic [7:0] b, input logic last,
		output verdict_t v);
		logic [15:0] pos;
		logic [15:0] tcp_at;
		logic [3:0]  st;
		int          len;
		int          iph;
		int          tcph;
		int          tcp_end;

		v = '0;
		pos = hdr_seen.frame_len;
		tcp_at = ETH_HDR_LEN + {hdr_seen.ihl, 2'b00};

		case (pos)
			POS_ETYPE_HI: hdr_seen.ether_type[15:8] = b;
			POS_ETYPE_LO: hdr_seen.ether_type[7:0] = b;
			POS_IHL:      hdr_seen.ihl = b[3:0];
			POS_LEN_HI:   hdr_seen.ip_len[15:8] = b;
			POS_LEN_LO:   hdr_seen.ip_len[7:0] = b;
			POS_PROTO:    hdr_seen.proto = b;
			default: ;
		endcase
		// IHL is already this byte's value here, so position 14 briefly
		// loads the port high byte; the real TCP start overwrites it later.
		if (hdr_seen.ihl >= 4'd5) begin
			if (pos == tcp_at)
				hdr_seen.src_port[15:8] = b;
			if (pos == tcp_at + 16'd1)
				hdr_seen.src_port[7:0] = b;
			if (pos == tcp_at + 16'd12)
				hdr_seen.doff = b[7:4];
		end
		if (hdr_seen.frame_len != POS_MAX)
			hdr_seen.frame_len++;

		if (!last)
			return 1'b0;

		len = hdr_seen.frame_len;
		iph = 4 * hdr_seen.ihl;
		tcph = 4 * hdr_seen.doff;
		tcp_end = ETH_HDR_LEN + iph;

		// first failing check wins
		if (len < ETH_HDR_LEN)
			st = ST_SHORT_ETH;
		else if (hdr_seen.ether_type != ETHERTYPE_IPV4)
			st = ST_NOT_IPV4;
		else if (len < ETH_HDR_LEN + IP_MIN_LEN)
			st = ST_SHORT_IP;
		else if (iph < IP_MIN_LEN)
			st = ST_BAD_IHL;
		else if (hdr_seen.proto != PROTO_TCP)
			st = ST_NOT_TCP;
		else if (len < tcp_end + TCP_MIN_LEN)
			st = ST_SHORT_TCP;
		else if (tcph < TCP_MIN_LEN)
			st = ST_BAD_DOFF;
		else if (hdr_seen.src_port != port_setting || int'(hdr_seen.ip_len) < iph + tcph + 1)
			st = ST_PORT_PAYL;
		else
			st = ST_ACCEPT;

		v.status = st;
		v.ip_header_bytes = (st == ST_ACCEPT || st >= ST_BAD_IHL) ? 6'(iph) : 6'd0;
		v.tcp_header_bytes = (st == ST_ACCEPT || st >= ST_BAD_DOFF) ? 6'(tcph) : 6'd0;
		v.payload_offset = (st == ST_ACCEPT) ? 8'(tcp_end + tcph) : 8'd0;
		v.ip_total_length = (st == ST_ACCEPT || st >= ST_BAD_IHL) ? hdr_seen.ip_len : 16'd0;
		v.frame_bytes = hdr_seen.frame_len;

		hdr_seen = '0;
		return 1'b1;
	endfunction

	// ------------------------------------------------------------------
	// Byte driver. Entered on a clock edge; returns on the edge at which the
	// word is taken, leaving valid high so back-to-back words need no gap.
	// ------------------------------------------------------------------
	task automatic send_byte(input logic [7:0] b, input logic last);
		int       gap;
		verdict_t v;

		gap = gaps_enabled ? $urandom_range(0, 5) : 0;
		if (gap > 0) begin
			frame_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		frame_ch.valid <= 1'b1;
		frame_ch.data_byte <= b;
		frame_ch.last_byte <= last;
		do
			@(posedge clk);
		while (!frame_ch.ready);
		bytes_sent++;
		if (track_frame_byte(b, last, v))
			expected_verdicts.push_back(v);
	endtask

	task automatic send_frame(ref logic [7:0] f[$]);
		foreach (f[i])
			send_byte(f[i], i == f.size() - 1);
	endtask

	// Drop valid, let every verdict arrive, then give the pipeline time to
	// settle before anything else happens.
	task automatic wait_idle();
		frame_ch.valid <= 1'b0;
		while (expected_verdicts.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_port(input logic [15:0] value);
		wait_idle();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		port_setting = value;
	endtask

	// Builds a frame with the given header fields; the rest is random.
	// IHL or data offset below 5 still gets a 20-byte header laid down.
	task automatic make_frame(ref logic [7:0] f[$], input logic [15:0] etype,
		input logic [3:0] ihl, input logic [15:0] ip_len, input logic [7:0] proto,
		input logic [15:0] sport, input logic [3:0] doff, input int payload_n);
		int ip_bytes;
		int tcp_bytes;

		ip_bytes = (ihl < 4'd5) ? 20 : 4 * ihl;
		tcp_bytes = (doff < 4'd5) ? 20 : 4 * doff;
		f.delete();
		repeat (12) f.push_back(8'($urandom));
		f.push_back(etype[15:8]);
		f.push_back(etype[7:0]);
		// IP header: version nibble left random, it is not checked
		f.push_back({4'($urandom), ihl});
		f.push_back(8'($urandom));
		f.push_back(ip_len[15:8]);
		f.push_back(ip_len[7:0]);
		repeat (5) f.push_back(8'($urandom));
		f.push_back(proto);
		repeat (ip_bytes - 10) f.push_back(8'($urandom));
		// TCP header
		f.push_back(sport[15:8]);
		f.push_back(sport[7:0]);
		repeat (10) f.push_back(8'($urandom));
		f.push_back({doff, 4'($urandom)});
		repeat (tcp_bytes - 13) f.push_back(8'($urandom));
		repeat (payload_n) f.push_back(8'($urandom));
	endtask

	task automatic cut_frame(ref logic [7:0] f[$], input int n);
		while (f.size() > n)
			void'(f.pop_back());
	endtask

	// Mostly well-formed frames with random content, some with one header
	// field spoilt, some cut short, and some plain line noise.
	task automatic build_random_frame(ref logic [7:0] f[$]);
		int          kind;
		int          ihl;
		int          doff;
		int          hdr_sum;
		int          doff_at;
		logic [15:0] sport;
		logic [15:0] ip_len;

		kind = $urandom_range(0, 99);
		if (kind >= 85) begin
			f.delete();
			repeat ($urandom_range(1, 60)) f.push_back(8'($urandom));
			return;
		end
		ihl = $urandom_range(5, 15);
		doff = $urandom_range(5, 15);
		hdr_sum = 4 * (ihl + doff);
		doff_at = ETH_HDR_LEN + 4 * ihl + 12;
		sport = ($urandom_range(0, 9) != 0) ? port_setting : 16'($urandom);
		case ($urandom_range(0, 3))
			0: ip_len = 16'(hdr_sum + $urandom_range(1, 40));
			1: ip_len = 16'(hdr_sum);
			2: ip_len = 16'($urandom_range(0, hdr_sum));
			default: ip_len = 16'($urandom);
		endcase
		make_frame(f, ETHERTYPE_IPV4, 4'(ihl), ip_len, PROTO_TCP, sport, 4'(doff),
			$urandom_range(0, 12));
		if ($urandom_range(0, 99) < 20) begin
			case ($urandom_range(0, 3))
				0: f[POS_ETYPE_LO] = 8'($urandom);
				1: f[POS_PROTO] = 8'($urandom);
				2: f[POS_IHL] = {f[POS_IHL][7:4], 4'($urandom_range(0, 4))};
				default: f[doff_at] = {4'($urandom_range(0, 4)), f[doff_at][3:0]};
			endcase
		end
		// truncated heads up to the TCP header end, or rarely a cut anywhere
		if (kind >= 70)
			cut_frame(f, $urandom_range(1, ETH_HDR_LEN + hdr_sum));
		else if ($urandom_range(0, 99) < 10)
			cut_frame(f, $urandom_range(1, f.size()));
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Frames for every verdict code, with the boundary lengths and the field
	// extremes; runs on the port value left by reset.
	task automatic test_header_checks();
		logic [7:0] f[$];

		gaps_enabled = 1'b1;
		// accepted frame with the least IP total length, at the reset port
		make_frame(f, ETHERTYPE_IPV4, 4'd5, 16'd41, PROTO_TCP, PORT_RESET, 4'd5, 1);
		send_frame(f);
		// short Ethernet: one byte, then one byte short
		cut_frame(f, 1);
		send_frame(f);
		make_frame(f, ETHERTYPE_IPV4, 4'd5, 16'd41, PROTO_TCP, PORT_RESET, 4'd5, 1);
		cut_frame(f, ETH_HDR_LEN - 1);
		send_frame(f);
		// not IPv4, including a near miss
		make_frame(f, 16'h86DD, 4'd5, 16'd41, PROTO_TCP, PORT_RESET, 4'd5, 1);
		send_frame(f);
		make_frame(f, 16'h0801, 4'd5, 16'd41, PROTO_TCP, PORT_RESET, 4'd5, 1);
		send_frame(f);
		// Ethernet header alone, then IP header one byte short
		make_frame(f, ETHERTYPE_IPV4, 4'd5, 16'd41, PROTO_TCP, PORT_RESET, 4'd5, 1);
		cut_frame(f, ETH_HDR_LEN);
		send_frame(f);
		make_frame(f, ETHERTYPE_IPV4, 4'd5, 16'd41, PROTO_TCP, PORT_RESET, 4'd5, 1);
		cut_frame(f, ETH_HDR_LEN + IP_MIN_LEN - 1);
		send_frame(f);
		// bad IHL, zero and just below the minimum
		make_frame(f, ETHERTYPE_IPV4, 4'd0, 16'd41, PROTO_TCP, PORT_RESET, 4'd5, 1);
		send_frame(f);
		make_frame(f, ETHERTYPE_IPV4, 4'd4, 16'd41, PROTO_TCP, PORT_RESET, 4'd5, 1);
		send_frame(f);
		// not TCP
		make_frame(f, ETHERTYPE_IPV4, 4'd5, 16'd41, 8'd17, PORT_RESET, 4'd5, 1);
		send_frame(f);
		// short TCP: header ends exactly at the IP header, and a long IHL
		// with the TCP header one byte short
		make_frame(f, ETHERTYPE_IPV4, 4'd5, 16'd41, PROTO_TCP, PORT_RESET, 4'd5, 1);
		cut_frame(f, ETH_HDR_LEN + IP_MIN_LEN);
		send_frame(f);
		make_frame(f, ETHERTYPE_IPV4, 4'd15, 16'd100, PROTO_TCP, PORT_RESET, 4'd5, 4);
		cut_frame(f, ETH_HDR_LEN + 60 + TCP_MIN_LEN - 1);
		send_frame(f);
		// bad data offset
		make_frame(f, ETHERTYPE_IPV4, 4'd5, 16'd41, PROTO_TCP, PORT_RESET, 4'd0, 1);
		send_frame(f);
		make_frame(f, ETHERTYPE_IPV4, 4'd5, 16'd41, PROTO_TCP, PORT_RESET, 4'd4, 1);
		send_frame(f);
		// wrong port, then no payload: exact header sum and a zero length
		make_frame(f, ETHERTYPE_IPV4, 4'd5, 16'd41, PROTO_TCP, PORT_RESET + 16'd1, 4'd5, 1);
		send_frame(f);
		make_frame(f, ETHERTYPE_IPV4, 4'd5, 16'd40, PROTO_TCP, PORT_RESET, 4'd5, 1);
		send_frame(f);
		make_frame(f, ETHERTYPE_IPV4, 4'd5, 16'd0, PROTO_TCP, PORT_RESET, 4'd5, 0);
		send_frame(f);
		// largest headers and total length: payload offset at its maximum
		make_frame(f, ETHERTYPE_IPV4, 4'd15, 16'hFFFF, PROTO_TCP, PORT_RESET, 4'd15, 3);
		send_frame(f);
	endtask

	// Register extremes, a random value and back to the reset value; each
	// with a matching frame and one that differs in a single port bit.
	task automatic test_port_settings();
		logic [7:0]  f[$];
		logic [15:0] ports[4];

		ports[0] = 16'h0000;
		ports[1] = 16'hFFFF;
		ports[2] = 16'($urandom);
		ports[3] = PORT_RESET;
		foreach (ports[i]) begin
			write_port(ports[i]);
			make_frame(f, ETHERTYPE_IPV4, 4'd5, 16'd60, PROTO_TCP, ports[i], 4'd5, 2);
			send_frame(f);
			make_frame(f, ETHERTYPE_IPV4, 4'd5, 16'd60, PROTO_TCP,
				ports[i] ^ (16'd1 << $urandom_range(0, 15)), 4'd5, 2);
			send_frame(f);
		end
	endtask

	// Random traffic in four phases, each on a fresh random port.
	task automatic test_random_traffic();
		logic [7:0] f[$];
		int         first_byte;

		for (int phase = 0; phase < 4; phase++) begin
			write_port(16'($urandom));
			first_byte = bytes_sent;
			while (bytes_sent - first_byte < PHASE_BYTES) begin
				gaps_enabled = ($urandom_range(0, 3) != 0);
				build_random_frame(f);
				send_frame(f);
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Verdict side: ready drops for a random number of cycles per word.
	// ------------------------------------------------------------------
	initial begin
		int stall;

		verdict_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = gaps_enabled ? $urandom_range(0, 5) : 0;
			if (stall > 0) begin
				verdict_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			verdict_ch.ready <= 1'b1;
			do
				@(posedge clk);
			while (!verdict_ch.valid);
		end
	end

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			error_count++;
		end
	endtask

	// Every verdict word taken is matched against the oldest prediction.
	always @(posedge clk) begin : verdict_check
		verdict_t want;

		if (verdict_ch.valid && verdict_ch.ready) begin
			if (expected_verdicts.size() == 0) begin
				$error("verdict with none expected: status %0d, frame_bytes %0d",
					verdict_ch.status, verdict_ch.frame_bytes);
				error_count++;
			end else begin
				want = expected_verdicts.pop_front();
				check_field("status", want.status, verdict_ch.status);
				check_field("ip_header_bytes", want.ip_header_bytes,
					verdict_ch.ip_header_bytes);
				check_field("tcp_header_bytes", want.tcp_header_bytes,
					verdict_ch.tcp_header_bytes);
				check_field("payload_offset", want.payload_offset, verdict_ch.payload_offset);
				check_field("ip_total_length", want.ip_total_length,
					verdict_ch.ip_total_length);
				check_field("frame_bytes", want.frame_bytes, verdict_ch.frame_bytes);
			end
		end
	end

	// Watchdog: too long with no word moving on either side ends the run.
	always @(posedge clk) begin : stall_watch
		if (!arst_n || (frame_ch.valid && frame_ch.ready)
				|| (verdict_ch.valid && verdict_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$error("no handshake for %0d cycles, %0d verdicts outstanding",
				STALL_LIMIT, expected_verdicts.size());
			$display("Regression FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		frame_ch.valid = 1'b0;
		frame_ch.data_byte = '0;
		frame_ch.last_byte = 1'b0;
		hdr_seen = '0;
		port_setting = PORT_RESET;
		error_count = 0;
		bytes_sent = 0;
		quiet_cycles = 0;
		gaps_enabled = 1'b1;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_header_checks();
		test_port_settings();
		test_random_traffic();
		wait_idle();

		if (error_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

/* files.f */
sv/eiptf_pkg.sv
sv/eiptf_if.sv
sv/eiptf_verdict.sv
sv/eth_ipv4_tcp_header_filter_core.sv
bench/eth_ipv4_tcp_header_filter_core_test.sv
